// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prp, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prp) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

// File: hw/rtl/fwmd_pkg.sv
// ----------------------------------------------------------------------------
// fwmd_pkg
// constants and shared types of the fir with matched real-path delay
// ----------------------------------------------------------------------------
package fwmd_pkg;

  localparam int MAX_TAPS     = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int ACC_W        = 64;

  localparam int TAP_COUNT_W  = 7;
  localparam int TAP_INDEX_W  = 6;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_AUX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_INDEX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_VALUE = 2'd3;

  // control shared by every cell of the ring
  typedef struct packed {
    logic shift;
    logic rotate;
    logic coef_we;
  } cell_ctl_t;

  // control of the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctl_t;

endpackage

// File: hw/rtl/fwmd_cell.sv
// ----------------------------------------------------------------------------
// fwmd_cell
// one ring cell: main sample, aux sample and tap, shift or rotate per cycle
// ----------------------------------------------------------------------------
module fwmd_cell #(
  parameter int SAMPLE_WIDTH = fwmd_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = fwmd_pkg::COEF_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fwmd_pkg::cell_ctl_t            ctl,
  input  logic                           coef_hit,
  input  logic signed [SAMPLE_WIDTH-1:0] main_prev,
  input  logic signed [SAMPLE_WIDTH-1:0] aux_prev,
  input  logic signed [SAMPLE_WIDTH-1:0] main_next,
  input  logic signed [SAMPLE_WIDTH-1:0] aux_next,
  input  logic signed [COEF_WIDTH-1:0]   coef_next,
  input  logic signed [COEF_WIDTH-1:0]   coef_wdata,
  output logic signed [SAMPLE_WIDTH-1:0] main_q,
  output logic signed [SAMPLE_WIDTH-1:0] aux_q,
  output logic signed [COEF_WIDTH-1:0]   coef_q
);

  logic signed [SAMPLE_WIDTH-1:0] main_r;
  logic signed [SAMPLE_WIDTH-1:0] aux_r;
  logic signed [COEF_WIDTH-1:0]   coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r <= '0;
      aux_r  <= '0;
      coef_r <= '0;
    end else begin
      if (ctl.shift) begin
        main_r <= main_prev;
        aux_r  <= aux_prev;
      end else if (ctl.rotate) begin
        main_r <= main_next;
        aux_r  <= aux_next;
      end
      if (ctl.rotate) begin
        coef_r <= coef_next;
      end else if (ctl.coef_we && coef_hit) begin
        coef_r <= coef_wdata;
      end
    end
  end

  assign main_q = main_r;
  assign aux_q  = aux_r;
  assign coef_q = coef_r;

endmodule

// File: hw/rtl/fwmd_mac.sv
// ----------------------------------------------------------------------------
// fwmd_mac
// registered multiply, saturating 64-bit accumulate, round and clip
// ----------------------------------------------------------------------------
module fwmd_mac #(
  parameter int SAMPLE_WIDTH = fwmd_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = fwmd_pkg::COEF_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fwmd_pkg::mac_ctl_t             ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [COEF_WIDTH-1:0]   coef,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int AW = fwmd_pkg::ACC_W;
  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam logic [AW-1:0] RND = {{(AW-1){1'b0}}, 1'b1} << (COEF_WIDTH - 2);
  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {a[AW-1], a} + {b[AW-1], b};
    if (s[AW] != s[AW-1]) begin
      return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end
    return s[AW-1:0];
  endfunction

  logic signed [PW-1:0] prod_r;
  logic                 vld_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] sh;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sample * coef;
    acc_r  <= acc_nxt;
  end

  assign prod_ext = AW'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (vld_r) begin
      acc_nxt = sat_add(acc_r, prod_ext);
    end
  end

  assign rnd  = sat_add(acc_r, RND);
  assign sh   = rnd >>> (COEF_WIDTH - 1);
  assign fits = (&sh[AW-1:SAMPLE_WIDTH-1]) || !(|sh[AW-1:SAMPLE_WIDTH-1]);

  assign result = fits ? sh[SAMPLE_WIDTH-1:0] : (sh[AW-1] ? S_MIN : S_MAX);

endmodule

// File: hw/rtl/fir_with_matched_delay_to_complex.sv
// ----------------------------------------------------------------------------
// fir_with_matched_delay_to_complex
// fir over main or aux samples with a delay-matched real path, complex result
// ----------------------------------------------------------------------------
// in_* carries one beat per sample pair (main, aux); out_* returns one beat
// per input beat: real = main sample delayed by floor((taps-1)/2), imag = fir
// sum over the selected input, rounded, shifted by COEF_WIDTH-1 and clipped.
// samples and taps sit in a ring of MAX_TAPS cells; after a beat is taken the
// ring turns once around, handing each entry in ring order to the single
// multiply-accumulate unit, then returns to its home position.
// the ring walk through the one multiplier leads to the output register; the
// next beat is accepted only once the ring is home and the previous result
// has been loaded into the output register.
// a finished result waits in the output register; while out_tready is low
// the block still accepts and processes the next beat and holds that result
// until the register frees up.
// synchronous reset clears histories, taps, state and valid flags and sets the configuration (taps=1, main input).
// taps are loaded by writing tap_index, then tap_value, while the block idles.
module fir_with_matched_delay_to_complex #(
  parameter int MAX_TAPS     = fwmd_pkg::MAX_TAPS,
  parameter int SAMPLE_WIDTH = fwmd_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = fwmd_pkg::COEF_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // sample_main, sample_aux
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_real, out_imag
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    out_tdata,
  input  logic                                   cfg_we,
  input  logic [fwmd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [COEF_WIDTH-1:0]                  cfg_data
);

  localparam int DATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int CNT_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int EW     = (TW > fwmd_pkg::TAP_COUNT_W) ? TW : fwmd_pkg::TAP_COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [fwmd_pkg::TAP_COUNT_W-1:0] tap_count_r;
  logic                             use_aux_r;
  logic [fwmd_pkg::TAP_INDEX_W-1:0] tap_index_r;

  logic [EW-1:0] tc_ext;
  logic [TW-1:0] eff_taps;
  logic [TW-1:0] delay;
  logic [TW-1:0] cnt_ext;

  logic accept;
  logic run;
  logic out_free;
  logic load_out;

  logic signed [SAMPLE_WIDTH-1:0] in_main;
  logic signed [SAMPLE_WIDTH-1:0] in_aux;
  logic signed [SAMPLE_WIDTH-1:0] main_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] aux_q  [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   coef_q [MAX_TAPS];
  logic [MAX_TAPS-1:0]            coef_hit;

  fwmd_pkg::cell_ctl_t cell_ctl;
  fwmd_pkg::mac_ctl_t  mac_ctl;

  logic signed [SAMPLE_WIDTH-1:0] mac_sample;
  logic signed [SAMPLE_WIDTH-1:0] mac_res;
  logic signed [SAMPLE_WIDTH-1:0] real_r;
  logic                           out_valid_r;
  logic [DATA_W-1:0]              out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= fwmd_pkg::TAP_COUNT_W'(1);
      use_aux_r   <= 1'b0;
      tap_index_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fwmd_pkg::REG_TAP_COUNT: tap_count_r <= cfg_data[fwmd_pkg::TAP_COUNT_W-1:0];
        fwmd_pkg::REG_USE_AUX:   use_aux_r   <= cfg_data[0];
        fwmd_pkg::REG_TAP_INDEX: tap_index_r <= cfg_data[fwmd_pkg::TAP_INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  assign tc_ext = EW'(tap_count_r);

  always_comb begin
    if (tc_ext == '0) begin
      eff_taps = TW'(1);
    end else if (tc_ext > EW'(MAX_TAPS)) begin
      eff_taps = TW'(MAX_TAPS);
    end else begin
      eff_taps = TW'(tc_ext);
    end
  end

  assign delay   = (eff_taps - TW'(1)) >> 1;
  assign cnt_ext = TW'(cnt_r);

  // sequencer
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign run       = (state_r == S_RUN);
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == S_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_TAPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // cell ring
  assign in_main = in_tdata[SAMPLE_WIDTH-1:0];
  assign in_aux  = in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  assign cell_ctl.shift   = accept;
  assign cell_ctl.rotate  = run;
  assign cell_ctl.coef_we = cfg_we && (cfg_index == fwmd_pkg::REG_TAP_VALUE);

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] main_prev;
    logic signed [SAMPLE_WIDTH-1:0] aux_prev;

    if (k == 0) begin : g_head
      assign main_prev = in_main;
      assign aux_prev  = in_aux;
    end else begin : g_body
      assign main_prev = main_q[k-1];
      assign aux_prev  = aux_q[k-1];
    end

    assign coef_hit[k] = (32'(tap_index_r) == 32'(k));

    fwmd_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .coef_hit  (coef_hit[k]),
      .main_prev (main_prev),
      .aux_prev  (aux_prev),
      .main_next (main_q[(k+1) % MAX_TAPS]),
      .aux_next  (aux_q[(k+1) % MAX_TAPS]),
      .coef_next (coef_q[(k+1) % MAX_TAPS]),
      .coef_wdata(cfg_data),
      .main_q    (main_q[k]),
      .aux_q     (aux_q[k]),
      .coef_q    (coef_q[k])
    );
  end

  // multiply-accumulate at the ring head
  assign mac_sample     = use_aux_r ? aux_q[0] : main_q[0];
  assign mac_ctl.clear  = accept;
  assign mac_ctl.mul_en = run && (cnt_ext < eff_taps);

  fwmd_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .sample(mac_sample),
    .coef  (coef_q[0]),
    .result(mac_res)
  );

  // delayed real sample passes the head during the walk
  always_ff @(posedge clk) begin
    if (run && (cnt_ext == delay)) begin
      real_r <= main_q[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= DATA_W'({mac_res, real_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/fwmd_chk.sv
// ----------------------------------------------------------------------------
// fwmd_chk
// port-level checks of the fir block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwmd_chk #(
  parameter int SAMPLE_WIDTH = fwmd_pkg::SAMPLE_WIDTH
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata
);

  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "out beat dropped while stalled")
  `ASSERT_CLK(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "out data changed while stalled")
  `ASSERT_CLK(a_reset_idle, $rose(rst_n) |-> !out_tvalid, "out valid right after reset")
  `ASSERT_NEVER(a_one_at_a_time, $past(in_tvalid && in_tready) && in_tready, "ready right after a beat")

endmodule

bind fir_with_matched_delay_to_complex fwmd_chk #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_fwmd_chk (.*);
